/* rtl/stuffed_info_frame_builder_top_macros.svh */
// Assertion macros used by the frame builder checker.
`ifndef STUFFED_INFO_FRAME_BUILDER_TOP_MACROS_SVH
`define STUFFED_INFO_FRAME_BUILDER_TOP_MACROS_SVH

// Clocked check, muted while reset is held.
`define SIF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SIF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sif_pkg.sv */
// Shared types and constants for the stuffed information frame builder.
`default_nettype none

package sif_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_FLAG      = 3'd0;
    localparam logic [IDX_W-1:0] REG_ESCAPE    = 3'd1;
    localparam logic [IDX_W-1:0] REG_FLAG_SUB  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ESC_SUB   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ADDRESS   = 3'd4;
    localparam logic [IDX_W-1:0] REG_CTRL_EVEN = 3'd5;
    localparam logic [IDX_W-1:0] REG_CTRL_ODD  = 3'd6;

    // Reset values
    localparam logic [BYTE_W-1:0] RST_FLAG      = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd125;
    localparam logic [BYTE_W-1:0] RST_FLAG_SUB  = 8'd94;
    localparam logic [BYTE_W-1:0] RST_ESC_SUB   = 8'd93;
    localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CTRL_EVEN = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CTRL_ODD  = 8'd64;

    typedef struct packed {
        logic [BYTE_W-1:0] flag;
        logic [BYTE_W-1:0] escape;
        logic [BYTE_W-1:0] flag_sub;
        logic [BYTE_W-1:0] esc_sub;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] ctrl_even;
        logic [BYTE_W-1:0] ctrl_odd;
    } cfg_t;

    // One classified payload word handed from front to back
    typedef struct packed {
        logic              hdr;     // open a frame: send header first
        logic [BYTE_W-1:0] ctrl;    // control byte picked by sequence bit
        logic [BYTE_W-1:0] data;    // payload byte
        logic              chk_en;  // close the frame after this byte
        logic [BYTE_W-1:0] chk;     // frame check, valid when chk_en
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/sif_cfg.sv */
// Configuration register file of the frame builder.
`default_nettype none

module sif_cfg
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [sif_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [sif_pkg::BYTE_W-1:0]  cfg_data,
    output sif_pkg::cfg_t                    cfg
);

    sif_pkg::cfg_t cfg_reg;
    sif_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode; unused indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sif_pkg::REG_FLAG:      cfg_next.flag      = cfg_data;
                sif_pkg::REG_ESCAPE:    cfg_next.escape    = cfg_data;
                sif_pkg::REG_FLAG_SUB:  cfg_next.flag_sub  = cfg_data;
                sif_pkg::REG_ESC_SUB:   cfg_next.esc_sub   = cfg_data;
                sif_pkg::REG_ADDRESS:   cfg_next.address   = cfg_data;
                sif_pkg::REG_CTRL_EVEN: cfg_next.ctrl_even = cfg_data;
                sif_pkg::REG_CTRL_ODD:  cfg_next.ctrl_odd  = cfg_data;
                default:                cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag      <= sif_pkg::RST_FLAG;
            cfg_reg.escape    <= sif_pkg::RST_ESCAPE;
            cfg_reg.flag_sub  <= sif_pkg::RST_FLAG_SUB;
            cfg_reg.esc_sub   <= sif_pkg::RST_ESC_SUB;
            cfg_reg.address   <= sif_pkg::RST_ADDRESS;
            cfg_reg.ctrl_even <= sif_pkg::RST_CTRL_EVEN;
            cfg_reg.ctrl_odd  <= sif_pkg::RST_CTRL_ODD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sif_front.sv */
// Front end: accepts payload words, tracks the frame and running check.
`default_nettype none

module sif_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sif_pkg::BYTE_W-1:0]  payload_byte,
    input  wire logic                        first_of_packet,
    input  wire logic                        last_of_packet,
    input  wire logic                        sequence_bit,
    input  wire sif_pkg::cfg_t               cfg,
    input  wire logic                        q_full,
    output logic                             q_push,
    output sif_pkg::cmd_t                    q_cmd
);

    logic                       frame_open_reg;
    logic                       frame_open_next;
    logic [sif_pkg::BYTE_W-1:0] check_reg;
    logic [sif_pkg::BYTE_W-1:0] check_next;
    logic                       accept;
    logic                       keep;
    logic [sif_pkg::BYTE_W-1:0] check_base;
    logic [sif_pkg::BYTE_W-1:0] check_upd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // A word with no open frame and no start is dropped
    assign keep       = first_of_packet || frame_open_reg;
    assign check_base = first_of_packet ? '0 : check_reg;
    assign check_upd  = check_base ^ payload_byte;

    assign q_push      = accept && keep;
    assign q_cmd.hdr    = first_of_packet;
    assign q_cmd.ctrl   = sequence_bit ? cfg.ctrl_odd : cfg.ctrl_even;
    assign q_cmd.data   = payload_byte;
    assign q_cmd.chk_en = last_of_packet;
    assign q_cmd.chk    = check_upd;

    // Frame state update
    always_comb
    begin
        frame_open_next = frame_open_reg;
        check_next      = check_reg;
        if (q_push)
        begin
            if (last_of_packet)
            begin
                frame_open_next = 1'b0;
                check_next      = '0;
            end
            else
            begin
                frame_open_next = 1'b1;
                check_next      = check_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            check_reg      <= '0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            check_reg      <= check_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sif_fifo.sv */
// Short command queue between front and back.
`default_nettype none

module sif_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sif_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output sif_pkg::cmd_t      head_cmd,
    output logic               full,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    sif_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    // Pointer and fill-count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/sif_back.sv */
// Back end: expands queued commands into stuffed line bytes.
`default_nettype none

module sif_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sif_pkg::cfg_t               cfg,
    input  wire sif_pkg::cmd_t               head_cmd,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [sif_pkg::BYTE_W-1:0]       line_byte,
    output logic                             closing_flag,
    output logic                             run_last
);

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_FLAG  = 4'd0;
    localparam logic [PH_W-1:0] PH_ADDR  = 4'd1;
    localparam logic [PH_W-1:0] PH_CTRL  = 4'd2;
    localparam logic [PH_W-1:0] PH_HCS   = 4'd3;
    localparam logic [PH_W-1:0] PH_DATA  = 4'd4;
    localparam logic [PH_W-1:0] PH_DSUB  = 4'd5;
    localparam logic [PH_W-1:0] PH_CHK   = 4'd6;
    localparam logic [PH_W-1:0] PH_CSUB  = 4'd7;
    localparam logic [PH_W-1:0] PH_CLOSE = 4'd8;

    logic [PH_W-1:0]            phase_reg;
    logic [PH_W-1:0]            phase_next;
    logic                       mid_reg;
    logic                       mid_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [sif_pkg::BYTE_W-1:0] byte_reg;
    logic                       closing_reg;
    logic                       last_reg;

    logic [PH_W-1:0]            cur_phase;
    logic                       advance;
    logic                       emit;
    logic [sif_pkg::BYTE_W-1:0] sel_byte;
    logic                       sel_closing;
    logic                       sel_end;
    logic [PH_W-1:0]            sel_next;
    logic                       d_is_flag;
    logic                       d_is_esc;
    logic                       c_is_flag;
    logic                       c_is_esc;

    assign out_valid    = out_valid_reg;
    assign line_byte    = byte_reg;
    assign closing_flag = closing_reg;
    assign run_last     = last_reg;

    // Output slot frees when empty or being taken
    assign advance = !out_valid_reg || out_ready;
    assign emit    = advance && !q_empty;
    assign q_pop   = emit && sel_end;

    // A fresh command starts at the header or straight at its data byte
    assign cur_phase = mid_reg ? phase_reg : (head_cmd.hdr ? PH_FLAG : PH_DATA);

    // Flag match wins when flag and escape are equal
    assign d_is_flag = (head_cmd.data == cfg.flag);
    assign d_is_esc  = (head_cmd.data == cfg.escape);
    assign c_is_flag = (head_cmd.chk == cfg.flag);
    assign c_is_esc  = (head_cmd.chk == cfg.escape);

    // Byte selection per phase
    always_comb
    begin
        sel_byte    = cfg.flag;
        sel_closing = 1'b0;
        sel_end     = 1'b0;
        sel_next    = PH_FLAG;
        unique case (cur_phase)
            PH_FLAG:
            begin
                sel_byte = cfg.flag;
                sel_next = PH_ADDR;
            end
            PH_ADDR:
            begin
                sel_byte = cfg.address;
                sel_next = PH_CTRL;
            end
            PH_CTRL:
            begin
                sel_byte = head_cmd.ctrl;
                sel_next = PH_HCS;
            end
            PH_HCS:
            begin
                sel_byte = cfg.address ^ head_cmd.ctrl;
                sel_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (d_is_flag || d_is_esc)
                begin
                    sel_byte = cfg.escape;
                    sel_next = PH_DSUB;
                end
                else
                begin
                    sel_byte = head_cmd.data;
                    sel_end  = !head_cmd.chk_en;
                    sel_next = PH_CHK;
                end
            end
            PH_DSUB:
            begin
                sel_byte = d_is_flag ? cfg.flag_sub : cfg.esc_sub;
                sel_end  = !head_cmd.chk_en;
                sel_next = PH_CHK;
            end
            PH_CHK:
            begin
                if (c_is_flag || c_is_esc)
                begin
                    sel_byte = cfg.escape;
                    sel_next = PH_CSUB;
                end
                else
                begin
                    sel_byte = head_cmd.chk;
                    sel_next = PH_CLOSE;
                end
            end
            PH_CSUB:
            begin
                sel_byte = c_is_flag ? cfg.flag_sub : cfg.esc_sub;
                sel_next = PH_CLOSE;
            end
            PH_CLOSE:
            begin
                sel_byte    = cfg.flag;
                sel_closing = 1'b1;
                sel_end     = 1'b1;
                sel_next    = PH_FLAG;
            end
            default:
            begin
                sel_byte = cfg.flag;
                sel_end  = 1'b1;
                sel_next = PH_FLAG;
            end
        endcase
    end

    // Sequencer update
    always_comb
    begin
        phase_next     = phase_reg;
        mid_next       = mid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            if (sel_end)
            begin
                mid_next = 1'b0;
            end
            else
            begin
                mid_next   = 1'b1;
                phase_next = sel_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAG;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg    <= sel_byte;
            closing_reg <= sel_closing;
            last_reg    <= sel_end;
        end
    end

endmodule

`default_nettype wire

/* rtl/stuffed_info_frame_builder_top.sv */
// Top level of the stuffed information frame builder.
//
//  channel  direction  handshake            word
//  in       input      in_valid/in_ready    payload_byte, first/last_of_packet, sequence_bit
//  out      output     out_valid/out_ready  line_byte, closing_flag, run_last
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The back end sends one line byte per cycle while out is not stalled and a command waits;
// a kept word gives 1 line byte if plain, 2 if stuffed, up to 9 for a one-byte frame;
// dropped words give none. The front end takes a word per cycle while the queue has room.
// Reset clears the frame state, queue and output valid flag; config returns to defaults.
// A stall on out holds the output word; the queue then fills and drops in_ready.
`default_nettype none

module stuffed_info_frame_builder_top
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sif_pkg::BYTE_W-1:0]  payload_byte,
    input  wire logic                        first_of_packet,
    input  wire logic                        last_of_packet,
    input  wire logic                        sequence_bit,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [sif_pkg::BYTE_W-1:0]       line_byte,
    output logic                             closing_flag,
    output logic                             run_last,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [sif_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [sif_pkg::BYTE_W-1:0]  cfg_data
);

    sif_pkg::cfg_t cfg;
    sif_pkg::cmd_t push_cmd;
    sif_pkg::cmd_t head_cmd;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;

    sif_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sif_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .payload_byte    (payload_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .sequence_bit    (sequence_bit),
        .cfg             (cfg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (push_cmd)
    );

    sif_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    sif_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_cmd     (head_cmd),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_byte    (line_byte),
        .closing_flag (closing_flag),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire

/* rtl/sif_checker.sv */
// Port-level checker for the frame builder and its bind.
`default_nettype none

`include "stuffed_info_frame_builder_top_macros.svh"

module sif_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [sif_pkg::BYTE_W-1:0]  line_byte,
    input wire logic                        closing_flag,
    input wire logic                        run_last
);

    // Stalled output word holds
    `SIF_ASSERT(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable(line_byte) &&
            $stable(closing_flag) && $stable(run_last),
        "output word changed under stall")

    // Closing flag always ends the run of its input word
    `SIF_ASSERT(a_close_last,
        out_valid && closing_flag |-> run_last,
        "closing flag without run_last")

    // A closing flag is never directly followed by another one
    `SIF_ASSERT(a_close_gap,
        out_valid && out_ready && closing_flag |=> !(out_valid && closing_flag),
        "back-to-back closing flags")

    // Output is idle on the edge after any reset edge
    `SIF_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "output valid during reset")

endmodule

bind stuffed_info_frame_builder_top sif_checker u_sif_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_byte    (line_byte),
    .closing_flag (closing_flag),
    .run_last     (run_last)
);

`default_nettype wire
